>>> design/vlbs_pkg.sv
package vlbs_pkg;

    localparam int ELEMS = 12;
    localparam int LANES_MAX = 4;
    localparam logic [17:0] WEIGHT_STOP = 18'd32736;

    typedef struct packed {
        logic                 is_load;
        logic                 ld_ok;
        logic [7:0]           slot;
        logic [3:0]           elem;
        logic [2:0][31:0]     pos;
        logic [3:0][7:0]      jnt;
        logic [3:0][15:0]     wgt;
        logic [3:0]           take;
        logic                 taken;
    } vlbs_item_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> design/vlbs_ram.sv
module vlbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/vlbs_front.sv
module vlbs_front #(
    parameter int MAX_JOINTS = 64,
    parameter int INFLUENCES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          joint_count,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [191:0]        in_data,
    input  logic                in_kind,
    output logic                q_valid,
    input  logic                q_ready,
    output vlbs_pkg::vlbs_item_t q_item
);

    localparam int NL = (INFLUENCES < vlbs_pkg::LANES_MAX) ? INFLUENCES : vlbs_pkg::LANES_MAX;
    localparam logic [8:0] MAXJ = 9'(MAX_JOINTS);

    vlbs_pkg::vlbs_item_t item;
    vlbs_pkg::vlbs_item_t qmem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb
    begin
        logic [7:0]  slot;
        logic [7:0]  elem;
        logic [7:0]  j;
        logic [15:0] w;
        logic [17:0] wsum;
        logic        stop;
        logic        jok;
        item = '0;
        wsum = '0;
        stop = 1'b0;
        slot = in_data[103:96];
        elem = in_data[111:104];
        item.is_load = !in_kind;
        item.ld_ok = !slot[7] && ({1'b0, slot} < MAXJ) && !elem[7]
                     && (elem[6:0] < 7'(vlbs_pkg::ELEMS));
        item.slot = slot;
        item.elem = elem[3:0];
        item.pos[0] = in_data[31:0];
        item.pos[1] = in_data[63:32];
        item.pos[2] = in_data[95:64];
        for (int k = 0; k < vlbs_pkg::LANES_MAX; k++)
        begin
            j = in_data[96 + 8*k +: 8];
            w = in_data[128 + 16*k +: 16];
            jok = (k < NL) && !j[7] && (j[6:0] < joint_count) && ({2'b0, j[6:0]} < MAXJ);
            if ((w != 16'd0) && jok && !stop)
            begin
                item.take[k] = 1'b1;
                item.jnt[k] = j;
                item.wgt[k] = w;
                wsum = wsum + 18'(w);
                stop = (wsum >= vlbs_pkg::WEIGHT_STOP);
            end
        end
        item.taken = |item.take;
    end

    assign in_ready = (cnt_reg != 3'd4);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 3'd0);
    assign pop = q_valid && q_ready;
    assign q_item = qmem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/vlbs_back.sv
module vlbs_back #(
    parameter int MAX_JOINTS = 64,
    parameter int INFLUENCES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  vlbs_pkg::vlbs_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [95:0]          out_data,
    output logic                 out_flag
);

    localparam int NL = (INFLUENCES < vlbs_pkg::LANES_MAX) ? INFLUENCES : vlbs_pkg::LANES_MAX;
    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int NE = vlbs_pkg::ELEMS;

    logic pop, pop_skin, out_pop, ofifo_push;
    logic [3:0] credit_reg, credit_next;
    logic [31:0] ram_q [NL][NE];

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][31:0]    pos1_reg, pos2_reg, pos3_reg, pos4_reg;
    logic [15:0]         w1_reg [NL];
    logic [15:0]         w2_reg [NL];
    logic [15:0]         w3_reg [NL];
    logic [NL-1:0]       tk1_reg;
    logic                taken1_reg, taken2_reg, taken3_reg, taken4_reg;
    logic signed [63:0]  prod [NL][3][3];
    logic signed [63:0]  prod2_reg [NL][3][3];
    logic [31:0]         tr2_reg [NL][3];
    logic [31:0]         xf [NL][3];
    logic [31:0]         xf3_reg [NL][3];
    logic signed [48:0]  wp4_reg [NL][3];
    logic [95:0]         res_data;

    logic [96:0] omem_reg [8];
    logic [2:0]  owr_reg, owr_next, ord_reg, ord_next;
    logic [3:0]  ocnt_reg, ocnt_next;

    assign q_ready = q_item.is_load || (credit_reg < 4'd8);
    assign pop = q_valid && q_ready;
    assign pop_skin = pop && !q_item.is_load;

    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        for (genvar e = 0; e < NE; e++)
        begin : g_elem
            vlbs_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS)) u_ram (
                .clk     (clk),
                .wr_en   (pop && q_item.is_load && q_item.ld_ok && (q_item.elem == 4'(e))),
                .wr_addr (q_item.slot[JW-1:0]),
                .wr_data (q_item.pos[0]),
                .rd_addr (q_item.jnt[k][JW-1:0]),
                .rd_data (ram_q[k][e])
            );
        end
    end

    always_comb
    begin
        logic [31:0] m;
        for (int k = 0; k < NL; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    m = tk1_reg[k] ? ram_q[k][r*3 + c] : 32'd0;
                    prod[k][c][r] = $signed(pos1_reg[r]) * $signed(m);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [65:0] s;
        for (int k = 0; k < NL; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s = 66'(prod2_reg[k][c][0]) + 66'(prod2_reg[k][c][1])
                    + 66'(prod2_reg[k][c][2])
                    + $signed({{18{tr2_reg[k][c][31]}}, tr2_reg[k][c], 16'd0});
                xf[k][c] = vlbs_pkg::sat32(64'($signed(s[65:16])));
            end
        end
    end

    always_comb
    begin
        logic signed [50:0] tot;
        for (int c = 0; c < 3; c++)
        begin
            tot = '0;
            for (int k = 0; k < NL; k++)
            begin
                tot = tot + 51'(wp4_reg[k][c]);
            end
            res_data[32*c +: 32] = taken4_reg ? vlbs_pkg::sat32(64'($signed(tot[50:15])))
                                              : pos4_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        pos1_reg <= q_item.pos;
        taken1_reg <= q_item.taken;
        tk1_reg <= q_item.take[NL-1:0];
        pos2_reg <= pos1_reg;
        taken2_reg <= taken1_reg;
        pos3_reg <= pos2_reg;
        taken3_reg <= taken2_reg;
        pos4_reg <= pos3_reg;
        taken4_reg <= taken3_reg;
        for (int k = 0; k < NL; k++)
        begin
            w1_reg[k] <= q_item.wgt[k];
            w2_reg[k] <= w1_reg[k];
            w3_reg[k] <= w2_reg[k];
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    prod2_reg[k][c][r] <= prod[k][c][r];
                end
                tr2_reg[k][c] <= tk1_reg[k] ? ram_q[k][9 + c] : 32'd0;
                xf3_reg[k][c] <= xf[k][c];
                wp4_reg[k][c] <= $signed(xf3_reg[k][c]) * $signed({1'b0, w3_reg[k]});
            end
        end
        if (ofifo_push)
        begin
            omem_reg[owr_reg] <= {taken4_reg, res_data};
        end
    end

    assign ofifo_push = v4_reg;
    assign out_valid = (ocnt_reg != 4'd0);
    assign out_pop = out_valid && out_ready;
    assign out_data = omem_reg[ord_reg][95:0];
    assign out_flag = omem_reg[ord_reg][96];

    always_comb
    begin
        credit_next = credit_reg + {3'b0, pop_skin} - {3'b0, out_pop};
        owr_next = ofifo_push ? owr_reg + 3'd1 : owr_reg;
        ord_next = out_pop ? ord_reg + 3'd1 : ord_reg;
        ocnt_next = ocnt_reg + {3'b0, ofifo_push} - {3'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            credit_reg <= '0;
            owr_reg <= '0;
            ord_reg <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            v1_reg <= pop_skin;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            credit_reg <= credit_next;
            owr_reg <= owr_next;
            ord_reg <= ord_next;
            ocnt_reg <= ocnt_next;
        end
    end

endmodule

>>> design/vertex_linear_blend_skin_core.sv
// Channel  | Fields (low bit first)                                  | Per transfer
// s_axis   | tdata: pos_x pos_y pos_z joint_0..3 weight_0..3; tuser: action | one item
// m_axis   | tdata: out_x out_y out_z; tuser: blended                 | one skinned vertex
// cfg      | cfg_data: joint_count                                   | one register write
//
// One item is accepted per cycle while the input queue has room. A skin result passes
// through the input queue, the registered pipeline stages and the result FIFO before it is offered.
// The palette is kept as one RAM per influence and matrix element.
// Reset clears control state and joint_count; palette contents stay undefined until loaded.
// Input and output stall on their own through a four-entry queue and an eight-entry result FIFO.
module vertex_linear_blend_skin_core #(
    parameter int MAX_JOINTS = 64,
    parameter int INFLUENCES = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,       // joint_count
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, joint_0..3, weight_0..3
    input  logic [0:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
    output logic [0:0]   m_axis_tuser    // blended
);

    logic [6:0] joint_count_reg;
    logic       q_valid, q_ready;
    vlbs_pkg::vlbs_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            joint_count_reg <= cfg_data;
        end
    end

    vlbs_front #(.MAX_JOINTS(MAX_JOINTS), .INFLUENCES(INFLUENCES)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .joint_count (joint_count_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_kind     (s_axis_tuser[0]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    vlbs_back #(.MAX_JOINTS(MAX_JOINTS), .INFLUENCES(INFLUENCES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_flag  (m_axis_tuser[0])
    );

endmodule

>>> design/vlbs_checker.sv
module vlbs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    logic [4:0] pending_reg;
    logic       skin_in, res_out;

    assign skin_in = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
    assign res_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {4'b0, skin_in} - {4'b0, res_out};
        end
    end

    // A result needs a skin transfer that has not yet been answered.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pending_reg != 5'd0))
        else $error("result without pending skin transfer");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind vertex_linear_blend_skin_core vlbs_checker u_vlbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/vertex_linear_blend_skin_checker.sv
module vertex_linear_blend_skin_checker #(
    parameter int MAX_JOINTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending_count
);

    localparam int STOP_SUM = 32736;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        blended;
    } vertex_t;

    logic signed [31:0] palette [MAX_JOINTS*12];
    logic [6:0]         joint_count;
    vertex_t            skinned_q[$];

    assign pending_count = skinned_q.size();

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                       input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic vertex_t skin_vertex(input logic [191:0] d);
        vertex_t            r;
        logic signed [63:0] p [3];
        logic signed [63:0] acc [3];
        logic signed [79:0] t;
        logic signed [7:0]  j;
        int                 w;
        int                 wsum;
        bit                 taken;
        p[0] = 64'($signed(d[31:0]));
        p[1] = 64'($signed(d[63:32]));
        p[2] = 64'($signed(d[95:64]));
        acc = '{0, 0, 0};
        wsum = 0;
        taken = 0;
        for (int k = 0; k < 4; k++)
        begin
            j = d[96+8*k +: 8];
            w = int'(d[128+16*k +: 16]);
            if (w == 0 || j < 0 || int'(j) >= int'(joint_count) || int'(j) >= MAX_JOINTS)
                continue;
            for (int c = 0; c < 3; c++)
            begin
                // The products sum exactly in 80 bits before the single floor shift.
                t = 0;
                for (int rw = 0; rw < 3; rw++)
                    t += 80'(p[rw]) * 80'(palette[j*12 + rw*3 + c]);
                t = (t >>> 16) + 80'(palette[j*12 + 9 + c]);
                acc[c] += clamp32(64'(t)) * w;
            end
            taken = 1;
            wsum += w;
            if (wsum >= STOP_SUM)
                break;
        end
        for (int c = 0; c < 3; c++)
            acc[c] = taken ? clamp32(floor_shift(acc[c], 15)) : p[c];
        r.x = acc[0][31:0];
        r.y = acc[1][31:0];
        r.z = acc[2][31:0];
        r.blended = taken;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t          e;
        logic signed [7:0] slot;
        logic signed [7:0] el;
        if (!rst_n)
        begin
            joint_count <= '0;
            fail_count = 0;
            skinned_q.delete();
        end
        else
        begin
            if (cfg_we)
                joint_count <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                    skinned_q.insert(skinned_q.size(), skin_vertex(s_axis_tdata));
                else
                begin
                    slot = s_axis_tdata[103:96];
                    el = s_axis_tdata[111:104];
                    if (slot >= 0 && int'(slot) < MAX_JOINTS && el >= 0 && el < 12)
                        palette[slot*12 + el] = s_axis_tdata[31:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (skinned_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    e = skinned_q.pop_front();
                    if (m_axis_tdata[31:0] !== e.x)
                    begin
                        $error("out_x expected %h actual %h", e.x, m_axis_tdata[31:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[63:32] !== e.y)
                    begin
                        $error("out_y expected %h actual %h", e.y, m_axis_tdata[63:32]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tdata[95:64] !== e.z)
                    begin
                        $error("out_z expected %h actual %h", e.z, m_axis_tdata[95:64]);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tuser[0] !== e.blended)
                    begin
                        $error("blended expected %b actual %b", e.blended, m_axis_tuser[0]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/vertex_linear_blend_skin_core_tb.sv
module vertex_linear_blend_skin_core_tb;

    localparam int MAX_JOINTS = 64;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         cfg_we = 0;
    logic [6:0]   cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [95:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    int           fail_count;
    int           pending_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           loaded [MAX_JOINTS];
    bit           written [MAX_JOINTS][12];

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    vertex_linear_blend_skin_core #(.MAX_JOINTS(MAX_JOINTS), .INFLUENCES(4)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    vertex_linear_blend_skin_checker #(.MAX_JOINTS(MAX_JOINTS)) i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_item(input logic action, input logic [191:0] data);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= data;
        s_axis_tuser <= action;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_element(input int slot, input int el, input logic [31:0] v);
        bit full;
        send_item(1'b0, {64'($urandom) << 32 | 64'($urandom), 32'(el) << 8 | 32'(slot & 8'hff),
                         64'($urandom), v});
        if (slot >= 0 && slot < MAX_JOINTS && el >= 0 && el < 12)
        begin
            written[slot][el] = 1;
            full = 1;
            for (int e = 0; e < 12; e++)
                full = full && written[slot][e];
            loaded[slot] = full;
        end
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hffff;
            3: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // Joints not fully loaded are only named when they fall outside joint_count or MAX_JOINTS, or
    // carry no weight.
    function automatic logic [7:0] rand_joint();
        int j;
        case ($urandom_range(5))
            0: return 8'($urandom_range(255));
            default:
            begin
                j = $urandom_range(MAX_JOINTS - 1);
                return 8'(j);
            end
        endcase
    endfunction

    function automatic bit safe_joint(input logic [7:0] j, input int jc, input logic [15:0] w);
        int js;
        js = $signed(j);
        return w == 0 || js < 0 || js >= jc || js >= MAX_JOINTS || loaded[js];
    endfunction

    task automatic skin_vertex(input int jc, input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] jnt,
                               input logic [63:0] wgt);
        for (int k = 0; k < 4; k++)
            if (!safe_joint(jnt[8*k +: 8], jc, wgt[16*k +: 16]))
                jnt[8*k +: 8] = 8'hff;
        send_item(1'b1, {wgt, jnt, z, y, x});
    endtask

    task automatic random_vertex(input int jc);
        logic [31:0] jnt;
        logic [63:0] wgt;
        for (int k = 0; k < 4; k++)
        begin
            jnt[8*k +: 8] = rand_joint();
            wgt[16*k +: 16] = rand_weight();
        end
        skin_vertex(jc, rand_q16(), rand_q16(), rand_q16(), jnt, wgt);
    endtask

    task automatic quiesce();
        int saved;
        saved = send_idle_pct;
        s_axis_tvalid <= 0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        send_idle_pct = saved;
    endtask

    task automatic set_joint_count(input int jc);
        quiesce();
        cfg_we <= 1;
        cfg_data <= 7'(jc);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_pressure(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    initial
    begin
        int jc;
        int counts [6] = '{64, 1, 0, 33, 127, 17};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Palette: identity matrices with varied translations, extreme entries, then out-of-range loads.
        for (int j = 0; j < 4; j++)
            for (int el = 0; el < 12; el++)
                load_element(j, el, (el == 0 || el == 4 || el == 8) ? 32'h0001_0000 :
                             (el >= 9 ? 32'(j << 16) : 32'h0));
        for (int el = 0; el < 12; el++)
            load_element(MAX_JOINTS - 1, el, el[0] ? 32'h7fff_ffff : 32'h8000_0000);
        load_element(MAX_JOINTS, 0, 32'h1234_5678);
        load_element(-1, 0, 32'h1234_5678);
        load_element(0, 12, 32'h1234_5678);
        load_element(0, -1, 32'h1234_5678);
        set_joint_count(64);

        skin_vertex(64, 32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0302_0100, 64'h0);
        skin_vertex(64, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h3f3f_3f3f,
                    {4{16'd32768}});
        skin_vertex(64, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h003f_0100,
                    {16'hffff, 16'hffff, 16'hffff, 16'hffff});
        skin_vertex(64, 32'h0002_0000, 32'h1, 32'hffff_ffff, 32'h0302_0100,
                    {16'd8192, 16'd8192, 16'd8192, 16'd8192});
        skin_vertex(64, 32'h0002_0000, 32'h1, 32'hffff_ffff, 32'h0302_0100,
                    {16'd5, 16'd5, 16'd32736, 16'd0});
        skin_vertex(64, 32'h1, 32'h2, 32'h3, 32'h4080_c0ff, {4{16'd16384}});
        skin_vertex(64, 32'h1, 32'h2, 32'h3, 32'h0100_0203, {4{16'd1}});

        for (int phase = 0; phase < 12; phase++)
        begin
            set_pressure(phase);
            jc = counts[phase % 6];
            set_joint_count(jc);
            for (int n = 0; n < 125; n++)
            begin
                if ($urandom_range(9) == 0)
                    load_element($urandom_range(MAX_JOINTS + 1) - 1, $urandom_range(13) - 1,
                                 rand_q16());
                else
                    random_vertex(jc);
            end
            if (phase == 5)
                quiesce();
        end

        quiesce();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
